/* rtl/pso_pkg.sv */
// ----------------------------------------------------------------------------
// pso_pkg: shared types and constants for the PTP slave offset servo
// Sequencer states, operation targets, packet kinds, register indexes and
// fixed arithmetic constants.
// ----------------------------------------------------------------------------
package pso_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_STG,
    S_MUL,
    S_NORM,
    S_DIV,
    S_POST,
    S_APPLY,
    S_GISS,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    TGT_OFF,
    TGT_INT,
    TGT_GAIN
  } tgt_t;

  localparam logic [1:0] KIND_SYNC  = 2'd0;
  localparam logic [1:0] KIND_DRESP = 2'd1;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_GAIN0  = 2'd1;
  localparam logic [1:0] REG_GAIN1  = 2'd2;
  localparam logic [1:0] REG_GAIN2  = 2'd3;

  localparam logic [15:0] GAIN0_RST = 16'd256;
  localparam logic [15:0] GAIN1_RST = 16'd3200;
  localparam logic [15:0] GAIN2_RST = 16'd6400;

  localparam logic [29:0] DIV_NS   = 30'd1000000000;
  localparam logic [63:0] HALF_Q31 = 64'h0000_0000_8000_0000;
  localparam logic [63:0] SIGN_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

/* rtl/ptp_slave_offset_servo_unit.sv */
// ----------------------------------------------------------------------------
// ptp_slave_offset_servo_unit: PTP slave offset servo with cascaded integrator
// Sync beats record the forward delay and ask for a Delay_Req; Delay_Resp
// beats measure the offset and run the cascade to emit a Q32.32 rate factor.
//
// Input channel in_*: one beat per PTP timestamp event (kind, tx_stamp,
// rx_stamp, local_time). Result channel out_*: exactly one beat per input
// beat. Configuration port cfg_*: single-cycle writes of enable and gains.
//
// Sync, ignored kinds and a disabled-servo Delay_Resp go from accept straight
// to the done state. A Delay_Resp with the servo enabled runs the cascade on
// one shared 32x32 multiplier (four partial products per 64x64 product) and
// one divide-by-1e9 unit retiring four quotient bits a cycle; every offset,
// integration and gain product uses the multiplier, and offset and integration
// products the divider. One beat is worked on at a time.
//
// Reset clears the servo state and loads the default gains. A finished
// result sits in the output register; the block takes the next input beat
// while it waits, and holds the following result until out_ready drains it.
// ----------------------------------------------------------------------------
module ptp_slave_offset_servo_unit #(
  parameter int STAGES = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [62:0]        in_tx_stamp,
  input  logic [62:0]        in_rx_stamp,
  input  logic [62:0]        in_local_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_send_delay_req,
  output logic               out_factor_valid,
  output logic signed [63:0] out_rate_factor,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import pso_pkg::*;

  localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;

  function automatic logic [63:0] mag64(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] from_sign_mag(input logic neg, input logic [63:0] m);
    if (neg) return m[63] ? SIGN_MIN : (64'd0 - m);
    return m[63] ? POS_MAX : m;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) return a[63] ? SIGN_MIN : POS_MAX;
    return s;
  endfunction

  state_t             state_r, state_nxt;
  tgt_t               tgt_r, tgt_nxt;
  logic               div_mode_r, div_mode_nxt;
  logic               neg_r, neg_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [1:0]         sh_r, sh_nxt;
  logic [63:0]        op_a_r, op_a_nxt;
  logic [63:0]        op_b_r, op_b_nxt;
  logic [63:0]        pp_r, pp_nxt;
  logic [127:0]       acc_r, acc_nxt;
  logic [29:0]        rem_r, rem_nxt;
  logic [63:0]        q_r, q_nxt;
  logic [63:0]        sv_r, sv_nxt;
  logic [STG_W-1:0]   stg_r, stg_nxt;
  logic [63:0]        cur_r, cur_nxt;
  logic [63:0]        below_r, below_nxt;
  logic [63:0]        off_val_r, off_val_nxt;
  logic [63:0]        sm_r, sm_nxt;
  logic [62:0]        interval_r, interval_nxt;
  logic [63:0]        sum_r, sum_nxt;
  logic [63:0]        fwd_r, fwd_nxt;
  logic [62:0]        last_r, last_nxt;
  logic [63:0]        err_r   [STAGES];
  logic [63:0]        err_nxt [STAGES];
  logic               res_send_r, res_send_nxt;
  logic               res_fv_r, res_fv_nxt;
  logic [63:0]        res_rate_r, res_rate_nxt;

  logic               enable_r;
  logic [15:0]        gain0_r, gain1_r, gain2_r;
  logic               out_valid_r;
  logic               out_send_r;
  logic               out_fv_r;
  logic [63:0]        out_rate_r;

  logic [31:0]        a_part, b_part;
  logic [63:0]        prod;
  logic [127:0]       addend;
  logic [29:0]        dr;
  logic [30:0]        dt;
  logic [3:0]         qb;
  logic [15:0]        gain_cur;
  logic [31:0]        stg_ext;
  logic               out_load;

  assign stg_ext  = 32'(stg_r);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // shared multiplier and partial-product alignment
  assign a_part = cnt_r[1] ? op_a_r[63:32] : op_a_r[31:0];
  assign b_part = cnt_r[0] ? op_b_r[63:32] : op_b_r[31:0];
  assign prod   = a_part * b_part;

  always_comb begin
    case (sh_r)
      2'd0:    addend = {64'd0, pp_r};
      2'd1:    addend = {32'd0, pp_r, 32'd0};
      default: addend = {pp_r, 64'd0};
    endcase
  end

  // four quotient bits per cycle against 1e9
  always_comb begin
    dr = rem_r;
    dt = '0;
    qb = '0;
    for (int j = 0; j < 4; j++) begin
      dt = {dr, q_r[63-j]};
      if (dt >= {1'b0, DIV_NS}) begin
        dt        = dt - {1'b0, DIV_NS};
        qb[3-j]   = 1'b1;
      end
      dr = dt[29:0];
    end
  end

  always_comb begin
    if (stg_ext == 32'd0) begin
      gain_cur = gain0_r;
    end else if (stg_ext == 32'd1) begin
      gain_cur = gain1_r;
    end else if (stg_ext == 32'd2) begin
      gain_cur = gain2_r;
    end else begin
      gain_cur = 16'd0;
    end
  end

  always_comb begin
    logic [62:0] rx_eff;
    logic        ge;
    logic [63:0] b;
    logic [63:0] nv;

    state_nxt    = state_r;
    tgt_nxt      = tgt_r;
    div_mode_nxt = div_mode_r;
    neg_nxt      = neg_r;
    cnt_nxt      = cnt_r;
    sh_nxt       = sh_r;
    op_a_nxt     = op_a_r;
    op_b_nxt     = op_b_r;
    pp_nxt       = pp_r;
    acc_nxt      = acc_r;
    rem_nxt      = rem_r;
    q_nxt        = q_r;
    sv_nxt       = sv_r;
    stg_nxt      = stg_r;
    cur_nxt      = cur_r;
    below_nxt    = below_r;
    off_val_nxt  = off_val_r;
    sm_nxt       = sm_r;
    interval_nxt = interval_r;
    sum_nxt      = sum_r;
    fwd_nxt      = fwd_r;
    last_nxt     = last_r;
    err_nxt      = err_r;
    res_send_nxt = res_send_r;
    res_fv_nxt   = res_fv_r;
    res_rate_nxt = res_rate_r;
    in_ready     = 1'b0;
    rx_eff       = '0;
    ge           = 1'b0;
    b            = '0;
    nv           = '0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_send_nxt = 1'b0;
          res_fv_nxt   = 1'b0;
          res_rate_nxt = 64'd0;
          state_nxt    = S_DONE;
          case (in_kind)
            KIND_SYNC: begin
              rx_eff       = (in_rx_stamp == 63'd0) ? in_local_time : in_rx_stamp;
              fwd_nxt      = {1'b0, rx_eff} - {1'b0, in_tx_stamp};
              res_send_nxt = 1'b1;
            end
            KIND_DRESP: begin
              if (enable_r) begin
                sm_nxt       = {1'b0, in_rx_stamp} - {1'b0, in_tx_stamp};
                interval_nxt = in_local_time - last_r;
                last_nxt     = in_local_time;
                state_nxt    = S_PREP;
              end
            end
            default: ;
          endcase
        end
      end
      S_PREP: begin
        ge           = $signed(fwd_r) >= $signed(sm_r);
        op_a_nxt     = ge ? (fwd_r - sm_r) : (sm_r - fwd_r);
        op_b_nxt     = HALF_Q31;
        neg_nxt      = ge;
        tgt_nxt      = TGT_OFF;
        div_mode_nxt = 1'b1;
        acc_nxt      = '0;
        cnt_nxt      = '0;
        stg_nxt      = STG_W'(STAGES - 1);
        sum_nxt      = 64'd0;
        cur_nxt      = err_r[STAGES-1];
        state_nxt    = S_MUL;
      end
      S_STG: begin
        if (stg_r == '0) begin
          err_nxt[0] = off_val_r;
          cur_nxt    = off_val_r;
          state_nxt  = S_GISS;
        end else begin
          b            = err_r[stg_r - STG_W'(1)];
          below_nxt    = b;
          op_a_nxt     = mag64(b);
          op_b_nxt     = {1'b0, interval_r};
          neg_nxt      = b[63];
          tgt_nxt      = TGT_INT;
          div_mode_nxt = 1'b1;
          acc_nxt      = '0;
          cnt_nxt      = '0;
          state_nxt    = S_MUL;
        end
      end
      S_GISS: begin
        op_a_nxt     = mag64(cur_r);
        op_b_nxt     = {48'd0, gain_cur};
        neg_nxt      = cur_r[63];
        tgt_nxt      = TGT_GAIN;
        div_mode_nxt = 1'b0;
        acc_nxt      = '0;
        cnt_nxt      = '0;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        if (cnt_r <= 4'd3) begin
          pp_nxt = prod;
          sh_nxt = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
        end
        if (cnt_r != 4'd0) begin
          acc_nxt = acc_r + addend;
        end
        if (cnt_r == 4'd4) begin
          cnt_nxt   = '0;
          state_nxt = S_NORM;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_NORM: begin
        if (div_mode_r) begin
          if (acc_r[127:64] >= {34'd0, DIV_NS}) begin
            q_nxt     = '1;
            state_nxt = S_POST;
          end else begin
            rem_nxt   = acc_r[93:64];
            q_nxt     = acc_r[63:0];
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end
        end else begin
          q_nxt     = (acc_r[127:72] != '0) ? '1 : acc_r[71:8];
          state_nxt = S_POST;
        end
      end
      S_DIV: begin
        rem_nxt = dr;
        q_nxt   = {q_r[59:0], qb};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        sv_nxt    = from_sign_mag(neg_r, q_r);
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        case (tgt_r)
          TGT_OFF: begin
            off_val_nxt = sv_r;
            state_nxt   = S_STG;
          end
          TGT_INT: begin
            nv             = sat_add(cur_r, sv_r);
            err_nxt[stg_r] = nv;
            cur_nxt        = nv;
            state_nxt      = S_GISS;
          end
          TGT_GAIN: begin
            nv      = sat_add(sum_r, sv_r);
            sum_nxt = nv;
            if (stg_r == '0) begin
              res_send_nxt = 1'b0;
              res_fv_nxt   = 1'b1;
              res_rate_nxt = nv;
              state_nxt    = S_DONE;
            end else begin
              stg_nxt   = stg_r - STG_W'(1);
              cur_nxt   = below_r;
              state_nxt = S_STG;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      enable_r    <= 1'b1;
      gain0_r     <= GAIN0_RST;
      gain1_r     <= GAIN1_RST;
      gain2_r     <= GAIN2_RST;
      fwd_r       <= '0;
      last_r      <= '0;
      for (int k = 0; k < STAGES; k++) begin
        err_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      fwd_r   <= fwd_nxt;
      last_r  <= last_nxt;
      err_r   <= err_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE: enable_r <= cfg_data[0];
          REG_GAIN0:  gain0_r  <= cfg_data;
          REG_GAIN1:  gain1_r  <= cfg_data;
          REG_GAIN2:  gain2_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    div_mode_r <= div_mode_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    sh_r       <= sh_nxt;
    op_a_r     <= op_a_nxt;
    op_b_r     <= op_b_nxt;
    pp_r       <= pp_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    sv_r       <= sv_nxt;
    stg_r      <= stg_nxt;
    cur_r      <= cur_nxt;
    below_r    <= below_nxt;
    off_val_r  <= off_val_nxt;
    sm_r       <= sm_nxt;
    interval_r <= interval_nxt;
    sum_r      <= sum_nxt;
    res_send_r <= res_send_nxt;
    res_fv_r   <= res_fv_nxt;
    res_rate_r <= res_rate_nxt;
    if (out_load) begin
      out_send_r <= res_send_r;
      out_fv_r   <= res_fv_r;
      out_rate_r <= res_rate_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_send_delay_req = out_send_r;
  assign out_factor_valid   = out_fv_r;
  assign out_rate_factor    = $signed(out_rate_r);

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_send_delay_req && out_factor_valid))
    else $error("sync and factor flags both set");

  a_zero_factor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_factor_valid |-> out_rate_factor == 64'sd0)
    else $error("rate factor nonzero without factor_valid");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < DIV_NS)
    else $error("divider remainder out of range");

  a_last_corr: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_DRESP && enable_r
      |=> last_r == $past(in_local_time))
    else $error("correction time not taken from delay response");

endmodule

/* bench/servo_factor_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_factor_checker: result predictor and scoreboard for the offset servo
// Watches the input, result and register ports of the servo. Every accepted
// input beat runs through a bit-exact model of the offset measurement and the
// cascaded integrator, and the predicted result is queued. Every accepted
// result beat is compared field by field with the oldest queued prediction.
// The failure count and the number of outstanding predictions are reported
// back to the testbench top.
// ----------------------------------------------------------------------------
module servo_factor_checker
  import pso_pkg::*;
#(
  parameter int STAGES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [62:0] in_tx_stamp,
  input  logic [62:0] in_rx_stamp,
  input  logic [62:0] in_local_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_send_delay_req,
  input  logic        out_factor_valid,
  input  logic [63:0] out_rate_factor,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  localparam logic [31:0] Q8_ONE = 32'd256;

  typedef struct packed {
    logic        delay_req;
    logic        factor_ok;
    logic [63:0] factor;
  } servo_result_t;

  servo_result_t factors_due[$];

  logic        enable_q;
  logic [15:0] gain_q [3];
  logic [63:0] fwd_ns;
  logic [63:0] stage_q [STAGES];
  logic [62:0] last_fix_ns;
  int          fail_tally = 0;

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
                                                  logic [31:0] d);
    logic [127:0] q;
    q = ({64'd0, a} * {64'd0, b}) / {96'd0, d};
    return (q[127:64] != '0) ? '1 : q[63:0];
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic logic [63:0] signed_clip(logic neg, logic [63:0] m);
    if (neg) begin
      return (m >= SIGN_MIN) ? SIGN_MIN : -m;
    end
    return (m > POS_MAX) ? POS_MAX : m;
  endfunction

  function automatic logic [63:0] clip_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? SIGN_MIN : POS_MAX;
    end
    return s;
  endfunction

  function automatic servo_result_t servo_response(logic [1:0] kind, logic [62:0] tx,
                                                   logic [62:0] rx, logic [62:0] now);
    servo_result_t r;
    logic [63:0]   back_ns, span_ns, gap_mag, off_mag, below, term, prod, total, g;
    logic          fwd_first;
    int            i;
    r = '0;
    total = '0;
    if (kind == KIND_SYNC) begin
      fwd_ns = {1'b0, (rx == '0) ? now : rx} - {1'b0, tx};
      r.delay_req = 1'b1;
    end else if (kind == KIND_DRESP && enable_q) begin
      back_ns = {1'b0, rx} - {1'b0, tx};
      span_ns = {1'b0, now - last_fix_ns};
      fwd_first = $signed(fwd_ns) >= $signed(back_ns);
      gap_mag = fwd_first ? fwd_ns - back_ns : back_ns - fwd_ns;
      off_mag = scaled_quotient(gap_mag, HALF_Q31, {2'b00, DIV_NS});
      last_fix_ns = now;
      for (i = STAGES - 1; i >= 0; i--) begin
        if (i == 0) begin
          stage_q[0] = signed_clip(fwd_first, off_mag);
        end else begin
          below = stage_q[i-1];
          term = scaled_quotient(abs64(below), span_ns, {2'b00, DIV_NS});
          stage_q[i] = clip_add(stage_q[i], signed_clip(below[63], term));
        end
        if (i < 3) begin
          g = {48'd0, gain_q[i]};
        end else begin
          g = '0;
        end
        prod = scaled_quotient(abs64(stage_q[i]), g, Q8_ONE);
        total = clip_add(total, signed_clip(stage_q[i][63], prod));
      end
      r.factor_ok = 1'b1;
      r.factor = total;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    servo_result_t want;
    if (!rst_n) begin
      enable_q = 1'b1;
      gain_q[0] = GAIN0_RST;
      gain_q[1] = GAIN1_RST;
      gain_q[2] = GAIN2_RST;
      fwd_ns = '0;
      for (int k = 0; k < STAGES; k++) stage_q[k] = '0;
      last_fix_ns = '0;
      factors_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (factors_due.size() == 0) begin
          $display("%0t: result beat with none expected, actual req %b valid %b factor %h",
                   $time, out_send_delay_req, out_factor_valid, out_rate_factor);
          fail_tally++;
        end else begin
          want = factors_due.pop_front();
          if (out_send_delay_req !== want.delay_req) begin
            $display("%0t: send_delay_req expected %b actual %b",
                     $time, want.delay_req, out_send_delay_req);
            fail_tally++;
          end
          if (out_factor_valid !== want.factor_ok) begin
            $display("%0t: factor_valid expected %b actual %b",
                     $time, want.factor_ok, out_factor_valid);
            fail_tally++;
          end
          if (out_rate_factor !== want.factor) begin
            $display("%0t: rate_factor expected %h actual %h",
                     $time, want.factor, out_rate_factor);
            fail_tally++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE: enable_q = cfg_data[0];
          REG_GAIN0:  gain_q[0] = cfg_data;
          REG_GAIN1:  gain_q[1] = cfg_data;
          REG_GAIN2:  gain_q[2] = cfg_data;
        endcase
      end
      if (in_valid && in_ready) begin
        factors_due.push_back(servo_response(in_kind, in_tx_stamp, in_rx_stamp,
                                             in_local_time));
      end
    end
    mismatches <= fail_tally;
    pending <= factors_due.size();
  end

endmodule

/* bench/ptp_slave_offset_servo_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptp_slave_offset_servo_unit_test: stimulus and verdict for the offset servo
// Drives timestamp events into the servo: a directed opening over the stamp
// extremes, missing stamps, ignored kinds, a backwards local clock and the
// register extremes, then random Sync/Delay_Resp exchanges with jitter and
// clock skew mixed with full-range noise, across several gain and enable
// settings. Both channels idle in random bursts, except in phases 2 and 5.
// A checker alongside the servo predicts and compares every result beat.
// ----------------------------------------------------------------------------
module ptp_slave_offset_servo_unit_test;
  import pso_pkg::*;

  localparam int          SERVO_STAGES = 3;
  localparam int          PHASE_BEATS  = 325;
  localparam logic [1:0]  KIND_OTHER   = 2'd2;
  localparam logic [1:0]  KIND_SPARE   = 2'd3;
  localparam logic [62:0] STAMP_MAX    = '1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [62:0] in_tx_stamp = '0;
  logic [62:0] in_rx_stamp = '0;
  logic [62:0] in_local_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        out_send_delay_req;
  logic        out_factor_valid;
  logic signed [63:0] out_rate_factor;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int          mismatches;
  int          pending;
  logic        idling = 1'b1;
  int          useful_beats = 0;
  logic [62:0] clock_ns = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ptp_slave_offset_servo_unit #(.STAGES(SERVO_STAGES)) dut (.*);

  servo_factor_checker #(.STAGES(SERVO_STAGES)) checker_i (.*);

  function automatic logic [62:0] any_stamp();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[62:0] >> $urandom_range(0, 62);
  endfunction

  task automatic send_event(logic [1:0] kind, logic [62:0] tx, logic [62:0] rx,
                            logic [62:0] now);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_tx_stamp <= tx;
    in_rx_stamp <= rx;
    in_local_time <= now;
    do @(posedge clk); while (!in_ready);
    if (kind == KIND_SYNC || kind == KIND_DRESP) useful_beats++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_servo_regs(logic en, logic [15:0] g0, logic [15:0] g1,
                                 logic [15:0] g2);
    cfg_we <= 1'b1;
    cfg_index <= REG_ENABLE;
    cfg_data <= {15'd0, en};
    @(posedge clk);
    cfg_index <= REG_GAIN0;
    cfg_data <= g0;
    @(posedge clk);
    cfg_index <= REG_GAIN1;
    cfg_data <= g1;
    @(posedge clk);
    cfg_index <= REG_GAIN2;
    cfg_data <= g2;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_exchange();
    int unsigned path_ns;
    int          skew_ns;
    logic [62:0] arrive;
    path_ns = $urandom_range(0, 20000);
    skew_ns = $urandom_range(0, 400000) - 200000;
    if ($urandom_range(0, 49) == 0) begin
      clock_ns = any_stamp();
    end
    clock_ns = clock_ns + 63'($urandom_range(1, 3_000_000));
    arrive = clock_ns + 63'(path_ns) + 63'(skew_ns);
    if ($urandom_range(0, 7) == 0) begin
      send_event(KIND_SYNC, clock_ns, '0, arrive);
    end else begin
      send_event(KIND_SYNC, clock_ns, arrive, arrive + 63'($urandom_range(0, 500)));
    end
    if ($urandom_range(0, 9) != 0) begin
      clock_ns = clock_ns + 63'($urandom_range(1000, 500000));
      path_ns = path_ns + $urandom_range(0, 2000);
      send_event(KIND_DRESP, clock_ns, clock_ns + 63'(path_ns) + 63'(-skew_ns),
                 clock_ns + 63'($urandom_range(0, 300)));
    end
  endtask

  initial begin
    int pick;
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_event(KIND_DRESP, '0, '0, '0);
    send_event(KIND_SYNC, 63'd1000, '0, 63'd5000);
    send_event(KIND_DRESP, 63'd6000, 63'd9000, 63'd1_000_000_000);
    send_event(KIND_OTHER, STAMP_MAX, STAMP_MAX, STAMP_MAX);
    send_event(KIND_SPARE, any_stamp(), any_stamp(), any_stamp());
    send_event(KIND_SYNC, '0, STAMP_MAX, '0);
    send_event(KIND_DRESP, STAMP_MAX, '0, 63'd2_000_000_000);
    send_event(KIND_DRESP, '0, '0, 63'd5);
    send_event(KIND_SYNC, STAMP_MAX, 63'd1, STAMP_MAX);
    send_event(KIND_DRESP, '0, STAMP_MAX, STAMP_MAX);
    send_event(KIND_DRESP, 63'd12345, 63'd12345, '0);
    settle();
    load_servo_regs(1'b0, '1, '1, '1);
    send_event(KIND_DRESP, 63'd1, 63'd2, 63'd3);
    send_event(KIND_SYNC, 63'd100, 63'd300, 63'd400);
    settle();
    load_servo_regs(1'b1, '1, '1, '1);
    send_event(KIND_DRESP, 63'd200, 63'd500, 63'd3_000_000_000);
    send_event(KIND_DRESP, STAMP_MAX, '0, STAMP_MAX);
    settle();
    load_servo_regs(1'b1, '0, '0, '0);
    send_event(KIND_DRESP, 63'd7, 63'd11, 63'd4_000_000_000);
    send_event(KIND_SYNC, '0, '0, '0);
    settle();
    load_servo_regs(1'b1, 16'd1, 16'd1, 16'd1);
    send_event(KIND_DRESP, 63'd50, 63'd80, 63'd4_000_000_100);
    send_event(KIND_SYNC, 63'd900, 63'd1500, 63'd1600);
    send_event(KIND_DRESP, 63'd2000, 63'd2400, 63'd4_001_000_000);

    useful_beats = 0;
    clock_ns = any_stamp();
    for (phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: load_servo_regs(1'b1, GAIN0_RST, GAIN1_RST, GAIN2_RST);
        2: load_servo_regs(1'b1, '1, '1, '1);
        3: load_servo_regs(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
        4: load_servo_regs(1'b1, 16'($urandom_range(0, 512)), 16'($urandom_range(0, 4096)),
                           16'($urandom_range(0, 8192)));
        default: load_servo_regs(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      idling = (phase != 2) && (phase != 5);
      while (useful_beats < (phase + 1) * PHASE_BEATS) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          run_exchange();
        end else if (pick < 88) begin
          send_event(2'($urandom_range(KIND_OTHER, KIND_SPARE)), any_stamp(), any_stamp(),
                     any_stamp());
        end else begin
          send_event(2'($urandom_range(0, 3)), any_stamp(),
                     ($urandom_range(0, 7) == 0) ? '0 : any_stamp(), any_stamp());
        end
      end
    end

    settle();
    repeat (120) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
